// ===== design/dependency_cycle_detector_top_macros.svh =====
// ----------------------------------------------------------------------------
// dependency cycle detector assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_CYCLE_DETECTOR_TOP_MACROS_SVH
`define DEPENDENCY_CYCLE_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcd assertion failed");
`define DCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcd assertion failed");
`else
`define DCD_ASSERT(lbl, clk, rst_n, prop)
`define DCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg
// shared constants and types of the dependency cycle detector
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int DCD_MAX_NODES = 256;
    localparam int DCD_MAX_EDGES = 1024;
    localparam int NODE_W        = 8;
    localparam int NODE_IDS      = 1 << NODE_W;
    localparam int NCNT_W        = 9;

    typedef logic [1:0] mark_t;
    localparam mark_t MARK_UNSEEN   = 2'd0;
    localparam mark_t MARK_ON_STACK = 2'd1;
    localparam mark_t MARK_DONE     = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_ACYCLIC  = 2'd0;
    localparam status_t STATUS_CYCLE    = 2'd1;
    localparam status_t STATUS_BAD_NODE = 2'd2;
    localparam status_t STATUS_OVERFLOW = 2'd3;

endpackage

// ===== design/dependency_cycle_detector_top.sv =====
// ----------------------------------------------------------------------------
// dependency_cycle_detector_top
// stores directed edges, then on evaluate reports bad node or overflow if one was
// flagged, else runs a depth-first walk with three-state node marks and reports acyclic or cycle
//
//   channel   signals                            direction
//   input     in_valid in_ready kind from_node to_node   in
//   result    out_valid out_ready status         out
//   config    cfg_valid cfg_ready node_count     in
//
// edge transfers are accepted back to back while idle
// evaluate: clears all 256 node marks, probes each root, scans the stored
// edges from each stacked node, reads the target's mark when the edge leaves
// that node and pushes the target if unseen, and pops a node once its edges are done
// input stalls while a walk runs; a waiting result holds only the next evaluate
// ----------------------------------------------------------------------------
`include "dependency_cycle_detector_top_macros.svh"

module dependency_cycle_detector_top
    import dcd_pkg::*;
#(
    parameter int MAX_NODES = DCD_MAX_NODES,
    parameter int MAX_EDGES = DCD_MAX_EDGES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NCNT_W-1:0] node_count
);

    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW  = NODE_W + ECW;
    localparam int EW  = 2 * NODE_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_ROOT   = 4'd2;
    localparam logic [3:0] ST_ROOT_W = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_SCAN_W = 4'd5;
    localparam logic [3:0] ST_MARK_W = 4'd6;
    localparam logic [3:0] ST_POP_W  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [NCNT_W-1:0] ncnt_reg;
    logic [ECW-1:0]    edge_count_reg, edge_count_next;
    logic [1:0]        err_reg, err_next;
    logic [NCNT_W-1:0] root_reg, root_next;
    logic [NCNT_W-1:0] sp_reg, sp_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [NODE_W-1:0] top_node_reg, top_node_next;
    logic [ECW-1:0]    top_cur_reg, top_cur_next;
    logic [NODE_W-1:0] hit_reg, hit_next;
    status_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;

    logic [NCNT_W-1:0] n_eff;
    logic              in_xfer;
    logic              bad_node;

    logic              edge_we;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    logic [EW-1:0]     edge_wdata, edge_rdata;
    logic              mark_we;
    logic [NODE_W-1:0] mark_waddr, mark_raddr;
    mark_t             mark_wdata, mark_rdata;
    logic              stk_we;
    logic [NODE_W-1:0] stk_waddr, stk_raddr;
    logic [SW-1:0]     stk_wdata, stk_rdata;

    assign n_eff = (32'(ncnt_reg) > MAX_NODES) ? NCNT_W'(MAX_NODES) : ncnt_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign bad_node  = ({1'b0, from_node} >= n_eff) || ({1'b0, to_node} >= n_eff);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        err_next        = err_reg;
        root_next       = root_reg;
        sp_next         = sp_reg;
        clr_next        = clr_reg;
        top_node_next   = top_node_reg;
        top_cur_next    = top_cur_reg;
        hit_next        = hit_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        edge_we         = 1'b0;
        edge_waddr      = edge_count_reg[EAW-1:0];
        edge_wdata      = {from_node, to_node};
        edge_raddr      = top_cur_reg[EAW-1:0];
        mark_we         = 1'b0;
        mark_waddr      = clr_reg;
        mark_wdata      = MARK_UNSEEN;
        mark_raddr      = root_reg[NODE_W-1:0];
        stk_we          = 1'b0;
        stk_waddr       = NODE_W'(sp_reg - NCNT_W'(1));
        stk_wdata       = {top_node_reg, top_cur_reg};
        stk_raddr       = NODE_W'(sp_reg - NCNT_W'(2));

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!kind)
                    begin
                        if (bad_node)
                        begin
                            err_next[0] = 1'b1;
                        end
                        else if (edge_count_reg == ECW'(MAX_EDGES))
                        begin
                            err_next[1] = 1'b1;
                        end
                        else
                        begin
                            edge_we         = 1'b1;
                            edge_count_next = edge_count_reg + ECW'(1);
                        end
                    end
                    else if (err_reg[0])
                    begin
                        res_next   = STATUS_BAD_NODE;
                        state_next = ST_FIN;
                    end
                    else if (err_reg[1])
                    begin
                        res_next   = STATUS_OVERFLOW;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                mark_we  = 1'b1;
                clr_next = clr_reg + NODE_W'(1);
                if (&clr_reg)
                begin
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_reg >= n_eff)
                begin
                    res_next   = STATUS_ACYCLIC;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_ROOT_W;
                end
            end
            ST_ROOT_W:
            begin
                if (mark_rdata == MARK_UNSEEN)
                begin
                    mark_we       = 1'b1;
                    mark_waddr    = root_reg[NODE_W-1:0];
                    mark_wdata    = MARK_ON_STACK;
                    top_node_next = root_reg[NODE_W-1:0];
                    top_cur_next  = '0;
                    sp_next       = NCNT_W'(1);
                    state_next    = ST_SCAN;
                end
                else
                begin
                    root_next  = root_reg + NCNT_W'(1);
                    state_next = ST_ROOT;
                end
            end
            ST_SCAN:
            begin
                if (top_cur_reg == edge_count_reg)
                begin
                    mark_we    = 1'b1;
                    mark_waddr = top_node_reg;
                    mark_wdata = MARK_DONE;
                    sp_next    = sp_reg - NCNT_W'(1);
                    if (sp_reg == NCNT_W'(1))
                    begin
                        root_next  = root_reg + NCNT_W'(1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_POP_W;
                    end
                end
                else
                begin
                    top_cur_next = top_cur_reg + ECW'(1);
                    state_next   = ST_SCAN_W;
                end
            end
            ST_SCAN_W:
            begin
                mark_raddr = edge_rdata[NODE_W-1:0];
                hit_next   = edge_rdata[NODE_W-1:0];
                if (edge_rdata[EW-1:NODE_W] == top_node_reg)
                begin
                    state_next = ST_MARK_W;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_MARK_W:
            begin
                case (mark_rdata)
                    MARK_UNSEEN:
                    begin
                        stk_we        = 1'b1;
                        mark_we       = 1'b1;
                        mark_waddr    = hit_reg;
                        mark_wdata    = MARK_ON_STACK;
                        top_node_next = hit_reg;
                        top_cur_next  = '0;
                        sp_next       = sp_reg + NCNT_W'(1);
                        state_next    = ST_SCAN;
                    end
                    MARK_ON_STACK:
                    begin
                        res_next   = STATUS_CYCLE;
                        state_next = ST_FIN;
                    end
                    default:
                    begin
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_POP_W:
            begin
                top_node_next = stk_rdata[SW-1:ECW];
                top_cur_next  = stk_rdata[ECW-1:0];
                state_next    = ST_SCAN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_reg;
                    edge_count_next = '0;
                    err_next        = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ncnt_reg       <= NCNT_W'(256);
            edge_count_reg <= '0;
            err_reg        <= '0;
            root_reg       <= '0;
            sp_reg         <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            err_reg        <= err_next;
            root_reg       <= root_next;
            sp_reg         <= sp_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ncnt_reg <= node_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_node_reg <= top_node_next;
        top_cur_reg  <= top_cur_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
    end

    dcd_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dcd_ram #(.WIDTH(2), .DEPTH(NODE_IDS)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    dcd_ram #(.WIDTH(SW), .DEPTH(NODE_IDS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    `DCD_ASSERT_IMP(a_scan_has_frame, clk, rst_n, state_reg == ST_SCAN, sp_reg != '0)
    `DCD_ASSERT(a_count_bound, clk, rst_n, edge_count_reg <= ECW'(MAX_EDGES))
    `DCD_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FIN)
    `DCD_ASSERT_IMP(a_eval_leaves_idle, clk, rst_n, in_xfer && kind, ##1 state_reg != ST_IDLE)

endmodule

// ===== design/dcd_ram.sv =====
// ----------------------------------------------------------------------------
// dcd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
